>>> rtl/tspg_pkg.sv
// shared types and constants for the trapezoidal step profile generator
// no dependencies; imported by every rtl module of the block
package tspg_pkg;

    // operation codes
    localparam logic [2:0] OP_MOVE_REL = 3'd0;
    localparam logic [2:0] OP_MOVE_ABS = 3'd1;
    localparam logic [2:0] OP_TIMER    = 3'd2;
    localparam logic [2:0] OP_FAULT    = 3'd3;
    localparam logic [2:0] OP_HOME     = 3'd4;

    // motion phases as reported
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_ACCEL  = 3'd2;
    localparam logic [2:0] PH_STEADY = 3'd3;
    localparam logic [2:0] PH_SLOW   = 3'd4;

    // configuration register indexes
    localparam int          CFG_ADDR_W           = 3;
    localparam int          CFG_DATA_W           = 16;
    localparam logic [2:0]  CFG_START_PERIOD     = 3'd0;
    localparam logic [2:0]  CFG_PERIOD_SPAN      = 3'd1;
    localparam logic [2:0]  CFG_NO_RAMP_LIMIT    = 3'd2;
    localparam logic [2:0]  CFG_SHORT_RAMP_LIMIT = 3'd3;
    localparam logic [2:0]  CFG_INVERT_DIRECTION = 3'd4;

    // register reset values
    localparam logic [15:0] RST_START_PERIOD     = 16'd1000;
    localparam logic [15:0] RST_PERIOD_SPAN      = 16'd500;
    localparam logic [15:0] RST_NO_RAMP_LIMIT    = 16'd1000;
    localparam logic [15:0] RST_SHORT_RAMP_LIMIT = 16'd3200;

    // stream widths
    localparam int IN_W  = 40;
    localparam int OUT_W = 56;

    // ramp length: at most a quarter of a 2^31 step move
    localparam int RAMP_W = 30;

    typedef struct packed {
        logic capture;   // latch the input transaction
        logic calc;      // first execution step
        logic plan;      // second execution step
        logic load_out;  // copy the state into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_move;
        logic is_timer;
        logic need_div;
        logic div_done;
    } t_dp_sts;

endpackage

>>> rtl/trapezoidal_step_profile_generator.sv
// top level of the single-axis trapezoidal step profile generator
// uses tspg_pkg, tspg_ctrl, tspg_dp (which holds tspg_div)
//
// channel   direction  handshake                       payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready i_s_axis_tdata (40 bits)
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready o_m_axis_tdata (56 bits)
// cfg       in         i_cfg_wr_en, no wait            i_cfg_addr, i_cfg_wdata
//
// fault, home and unused codes: accept, calc step, then result load
// timer events and moves without a ramp, rejected moves too, add a
// planning step before the result load
// a ramped move runs the restoring divider, one quotient bit a cycle,
// for a quotient of 16 + FRACTION_BITS bits, 32 at the default
// one transaction in work at a time; the output register lets the next
// transaction be accepted while the last result is still waiting
// reset is synchronous, active low; no clearing pass
module trapezoidal_step_profile_generator
    import tspg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [2:0] operation, [34:3] move_amount, [35] use_accel, [39:36] zero
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // result transactions
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] step_level, [1] direction_level, [17:2] timer_period,
    // [49:18] position, [50] running, [53:51] phase, [54] move_rejected,
    // [55] zero
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing of accept, calc, plan, divide and result load
    tspg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // motion state, ramp arithmetic and the result register
    tspg_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

>>> rtl/tspg_div.sv
// restoring divider, one quotient bit per cycle
// uses tspg_pkg; instantiated by tspg_dp for the ramp increment
module tspg_div
    import tspg_pkg::*;
#(
    parameter int DW = 32,
    parameter int VW = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[VW-1:0] : shifted[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/tspg_dp.sv
// datapath: configuration, motion state, ramp arithmetic and output register
// uses tspg_pkg and tspg_div; driven by tspg_ctrl commands
module tspg_dp
    import tspg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]       i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic [OUT_W-1:0]      o_out_data
);

    localparam int FB = FRACTION_BITS;
    localparam int AW = FB + 1;
    localparam int SW = (FB + 17 > 33) ? FB + 17 : 33;
    localparam int DW = 16 + FB;

    // configuration
    logic [15:0] r_start_period;
    logic [15:0] r_period_span;
    logic [15:0] r_no_ramp;
    logic [15:0] r_short_ramp;
    logic        r_invert;

    // latched transaction and intermediate results
    logic [2:0]        r_op;
    logic [31:0]       r_amt;
    logic              r_use_accel;
    logic [31:0]       r_rel;
    logic [SW-1:0]     r_sum;
    logic [RAMP_W-1:0] r_ramp;
    logic [31:0]       r_steps;

    // motion state
    logic [31:0]   r_pos;
    logic          r_fwd;
    logic [2:0]    r_phase;
    logic [31:0]   r_start_left;
    logic [31:0]   r_accel_left;
    logic [31:0]   r_steady_left;
    logic [31:0]   r_slow_left;
    logic [31:0]   r_inc;
    logic [AW-1:0] r_acc;
    logic [15:0]   r_period;
    logic          r_pulse;
    logic          r_rejected;
    logic [OUT_W-1:0] r_out;

    logic [31:0]       steps;
    logic              ramp_on;
    logic [RAMP_W-1:0] ramp;
    logic              is_move;
    logic              is_timer;
    logic              need_div;

    logic              ovf;
    logic [15:0]       whole;
    logic [AW-1:0]     acc_next;
    logic [15:0]       period_dn;
    logic [16:0]       period_up_sum;
    logic [15:0]       period_up;
    logic [31:0]       accel_dec;
    logic [31:0]       steady_dec;
    logic [31:0]       slow_dec;
    logic [31:0]       start_dec;

    logic              div_done;
    logic [DW-1:0]     quotient;
    logic              q_sat;

    assign is_move  = (r_op == OP_MOVE_REL) || (r_op == OP_MOVE_ABS);
    assign is_timer = (r_op == OP_TIMER);

    // move planning
    assign steps   = r_rel[31] ? (32'd0 - r_rel) : r_rel;
    assign ramp_on = r_use_accel && (steps > 32'(r_no_ramp));
    always_comb begin
        if (!ramp_on) begin
            ramp = '0;
        end else if (steps <= 32'(r_short_ramp)) begin
            ramp = RAMP_W'(steps >> 2);
        end else begin
            ramp = RAMP_W'(steps >> 3);
        end
    end
    assign need_div = is_move && (r_rel != 32'd0) && (ramp != '0);

    // ramp tick on the registered sum
    assign ovf      = r_sum > (SW'(1) << FB);
    assign whole    = (|(r_sum >> (FB + 16))) ? 16'hFFFF : r_sum[FB+15:FB];
    assign acc_next = ovf ? AW'(r_sum[FB-1:0]) : r_sum[AW-1:0];

    assign period_dn     = ({1'b0, r_period} > ({1'b0, whole} + 17'd1)) ?
                           (r_period - whole) : 16'd1;
    assign period_up_sum = {1'b0, r_period} + {1'b0, whole};
    assign period_up     = period_up_sum[16] ? 16'hFFFF : period_up_sum[15:0];

    assign accel_dec  = r_accel_left - 32'd1;
    assign steady_dec = r_steady_left - 32'd1;
    assign slow_dec   = r_slow_left - 32'd1;
    assign start_dec  = r_start_left - 32'd1;

    tspg_div #(
        .DW (DW),
        .VW (RAMP_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.plan && need_div),
        .i_dividend ({r_period_span, {FB{1'b0}}}),
        .i_divisor  (ramp),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign q_sat = |(quotient >> 32);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_period <= RST_START_PERIOD;
            r_period_span  <= RST_PERIOD_SPAN;
            r_no_ramp      <= RST_NO_RAMP_LIMIT;
            r_short_ramp   <= RST_SHORT_RAMP_LIMIT;
            r_invert       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_START_PERIOD:     r_start_period <= i_cfg_wdata;
                CFG_PERIOD_SPAN:      r_period_span  <= i_cfg_wdata;
                CFG_NO_RAMP_LIMIT:    r_no_ramp      <= i_cfg_wdata;
                CFG_SHORT_RAMP_LIMIT: r_short_ramp   <= i_cfg_wdata;
                CFG_INVERT_DIRECTION: r_invert       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_in_data[2:0];
            r_amt       <= i_in_data[34:3];
            r_use_accel <= i_in_data[35];
        end
        if (i_cmd.calc) begin
            r_rel <= (r_op == OP_MOVE_REL) ? r_amt : (r_amt - r_pos);
            r_sum <= SW'(r_acc) + SW'(r_inc);
        end
        if (i_cmd.plan) begin
            r_ramp  <= ramp;
            r_steps <= steps;
        end
        if (i_cmd.load_out) begin
            r_out <= {1'b0, r_rejected, r_phase, (r_phase != PH_IDLE), r_pos,
                      r_period, (r_fwd ^ r_invert), r_pulse};
        end
    end

    // motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_fwd         <= 1'b0;
            r_phase       <= PH_IDLE;
            r_start_left  <= '0;
            r_accel_left  <= '0;
            r_steady_left <= '0;
            r_slow_left   <= '0;
            r_inc         <= '0;
            r_acc         <= '0;
            r_period      <= RST_START_PERIOD;
            r_pulse       <= 1'b0;
            r_rejected    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rejected <= 1'b0;
            end
            if (i_cmd.calc) begin
                if (r_op == OP_FAULT) begin
                    r_phase <= PH_IDLE;
                end else if (r_op == OP_HOME) begin
                    r_pos <= '0;
                end
            end
            if (i_cmd.plan && is_move) begin
                if (r_rel == 32'd0) begin
                    r_rejected <= 1'b1;
                end else begin
                    r_fwd         <= ~r_rel[31];
                    r_period      <= (r_start_period != 16'd0) ? r_start_period : 16'd1;
                    r_acc         <= '0;
                    r_inc         <= '0;
                    r_steady_left <= '0;
                    if (ramp == '0) begin
                        r_start_left <= steps;
                        r_accel_left <= '0;
                        r_slow_left  <= '0;
                        r_phase      <= PH_START;
                    end else begin
                        r_start_left <= '0;
                        r_accel_left <= 32'(ramp);
                        r_slow_left  <= 32'(ramp);
                        r_phase      <= PH_ACCEL;
                    end
                end
            end
            if (i_cmd.plan && is_timer && (r_phase != PH_IDLE)) begin
                if (!r_pulse) begin
                    r_pulse <= 1'b1;
                end else begin
                    // complete one step
                    r_pulse <= 1'b0;
                    r_pos   <= r_fwd ? (r_pos + 32'd1) : (r_pos - 32'd1);
                    unique case (r_phase)
                        PH_ACCEL: begin
                            r_accel_left <= accel_dec;
                            r_acc        <= acc_next;
                            if (ovf) begin
                                r_period <= period_dn;
                            end
                            if (accel_dec == 32'd0) begin
                                r_phase <= (r_steady_left != 32'd0) ? PH_STEADY :
                                           ((r_slow_left != 32'd0) ? PH_SLOW : PH_IDLE);
                            end
                        end
                        PH_STEADY: begin
                            r_steady_left <= steady_dec;
                            if (steady_dec == 32'd0) begin
                                r_phase <= (r_slow_left != 32'd0) ? PH_SLOW : PH_IDLE;
                            end
                        end
                        PH_SLOW: begin
                            r_slow_left <= slow_dec;
                            r_acc       <= acc_next;
                            if (ovf) begin
                                r_period <= period_up;
                            end
                            if (slow_dec == 32'd0) begin
                                r_phase <= PH_IDLE;
                            end
                        end
                        PH_START: begin
                            r_start_left <= start_dec;
                            if (start_dec == 32'd0) begin
                                r_phase <= PH_IDLE;
                            end
                        end
                        default: r_phase <= PH_IDLE;
                    endcase
                end
            end
            if (div_done) begin
                r_inc         <= q_sat ? 32'hFFFF_FFFF : 32'(quotient);
                r_steady_left <= r_steps - {1'b0, r_ramp, 1'b0};
            end
        end
    end

    assign o_sts.is_move  = is_move;
    assign o_sts.is_timer = is_timer;
    assign o_sts.need_div = need_div;
    assign o_sts.div_done = div_done;
    assign o_out_data     = r_out;

endmodule

>>> rtl/tspg_ctrl.sv
// controller: sequences one transaction through the datapath
// uses tspg_pkg; commands tspg_dp and owns the output valid flag
module tspg_ctrl
    import tspg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_PLAN,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.plan     = (r_state == S_PLAN);
        o_cmd.load_out = (r_state == S_EMIT) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= (i_sts.is_move || i_sts.is_timer) ? S_PLAN : S_EMIT;
                end
                S_PLAN: begin
                    r_state <= i_sts.need_div ? S_DIV : S_EMIT;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
